// File: hw/rtl/order_book_matcher_unit_macros.svh
// Assertion macros shared by the order book checker.
`ifndef ORDER_BOOK_MATCHER_UNIT_MACROS_SVH
`define ORDER_BOOK_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication under the checker's clock and reset.
`define OBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("order book check failed");

// Next-cycle implication under the checker's clock and reset.
`define OBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("order book check failed");

`endif

// File: hw/rtl/obm_pkg.sv
// Shared constants and codes of the order book matcher.
package obm_pkg;
  localparam int TICKERS_DEF = 64;
  localparam int DEPTH_DEF   = 16;
  localparam int TKW = 6;
  localparam int QW  = 9;
  localparam int PW  = 10;
  localparam int KW  = 2;
  localparam logic [PW-1:0] PRICE_MIN = 10'd10;
  localparam logic [PW-1:0] PRICE_MAX = 10'd1000;
  localparam logic [4:0] TRADE_CAP = 5'd31;
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_MATCH  = 1'b1;
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;
  localparam logic [KW-1:0] KIND_ACCEPT = 2'd0;
  localparam logic [KW-1:0] KIND_DROP   = 2'd1;
  localparam logic [KW-1:0] KIND_TRADE  = 2'd2;
  localparam logic [KW-1:0] KIND_DONE   = 2'd3;
endpackage

// File: hw/rtl/order_book_matcher_unit.sv
// Top level of the per-ticker limit order book with price-time matching.
//
// Use: raise start with in_op/in_side/in_ticker/in_quantity/in_price; the
// item is taken at a rising edge where start is high and busy is low. Busy
// drops in the cycle in which the item's final result is shown. Each result
// is on the out_ ports for one cycle with out_valid high; out_last marks the
// final one. The receiver cannot stall; results are never held back.
// Add: one result (accepted or dropped), registered in S_DEC.
// Match: the active ticker's two sides are read from the book memories one
// entry a cycle and insertion-sorted by one shared compare unit into lane
// registers, then one trade per cycle while the heads cross (at most
// TRADE_CAP trades), then the remainders are written back one entry a cycle
// and the done result follows. A match with an empty side or an invalid
// ticker gives its done result from S_DEC.
// Reset: a clearing pass zeroes the per-ticker counts of all tickers;
// busy is high during it. Book entries are not cleared.
module order_book_matcher_unit
  import obm_pkg::*;
#(
  parameter int TICKERS = TICKERS_DEF,
  parameter int DEPTH   = DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic           in_op,
  input  logic           in_side,
  input  logic [TKW-1:0] in_ticker,
  input  logic [QW-1:0]  in_quantity,
  input  logic [PW-1:0]  in_price,
  output logic           out_valid,
  output logic [KW-1:0]  out_kind,
  output logic [TKW-1:0] out_trade_ticker,
  output logic [QW-1:0]  out_trade_quantity,
  output logic [PW-1:0]  out_trade_price,
  output logic           out_last
);
  localparam int TW = (TICKERS > 1) ? $clog2(TICKERS) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MD = TICKERS * DEPTH;
  localparam int AW = (MD > 1) ? $clog2(MD) : 1;
  localparam int EW = QW + PW;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_DEC, S_GATH, S_TRADE, S_WBUY, S_WSELL, S_FIN
  } state_t;

  state_t state_r;

  // Latched item
  logic           op_r, side_r, ok_r;
  logic [TKW-1:0] tk_r;
  logic [TW-1:0]  tki_r;
  logic [QW-1:0]  qty_r;
  logic [PW-1:0]  price_r;
  logic [AW-1:0]  base_r;

  // Sorted lanes
  logic [QW-1:0] bq_r [DEPTH];
  logic [PW-1:0] bp_r [DEPTH];
  logic [QW-1:0] sq_r [DEPTH];
  logic [PW-1:0] sp_r [DEPTH];
  logic [CW-1:0] nb_r, ns_r, nbf_r, nsf_r;

  // Sequencer counters
  logic          gsel_r, pend_r;
  logic [CW-1:0] gidx_r, widx_r;
  logic [4:0]    trd_r;
  logic [TW-1:0] clr_r;

  // Memories
  logic [EW-1:0] buy_mem  [MD];
  logic [EW-1:0] sell_mem [MD];
  logic [CW-1:0] bcnt_mem [TICKERS];
  logic [CW-1:0] scnt_mem [TICKERS];
  logic [EW-1:0] buy_rd_q, sell_rd_q;
  logic [CW-1:0] bcnt_q, scnt_q;

  // Output registers
  logic           ov_r, ol_r;
  logic [KW-1:0]  ok_kind_r;
  logic [QW-1:0]  oq_r;
  logic [PW-1:0]  op_price_r;

  logic          in_ok;
  logic [TW-1:0] in_tki;
  logic [TW-1:0] cnt_addr;
  logic [AW-1:0] book_raddr, book_waddr;
  logic [EW-1:0] book_wdata;
  logic          buy_we, sell_we, bcnt_we, scnt_we;
  logic [CW-1:0] bcnt_wdata, scnt_wdata;
  logic          add_room;

  assign in_ok  = ({26'd0, in_ticker} < 32'(TICKERS));
  assign in_tki = TW'(in_ticker);
  assign busy   = (state_r != S_IDLE);

  assign out_valid          = ov_r;
  assign out_kind           = ok_kind_r;
  assign out_trade_ticker   = tk_r;
  assign out_trade_quantity = oq_r;
  assign out_trade_price    = op_price_r;
  assign out_last           = ol_r;

  // Shared insertion unit: place one entry into the selected sorted side
  logic [CW-1:0] ins_n;
  logic [QW-1:0] ins_q, cur_q [DEPTH], new_q [DEPTH];
  logic [PW-1:0] ins_p, cur_p [DEPTH], new_p [DEPTH];
  logic          ins_ok;
  logic [EW-1:0] ins_rd;

  always_comb begin
    logic          keep, pkeep;
    logic [QW-1:0] lq;
    logic [PW-1:0] lp;
    ins_rd = gsel_r ? sell_rd_q : buy_rd_q;
    ins_q  = ins_rd[QW-1:0];
    ins_p  = ins_rd[EW-1:QW];
    ins_ok = (ins_q != '0) && (ins_p >= PRICE_MIN) && (ins_p <= PRICE_MAX);
    ins_n  = gsel_r ? ns_r : nb_r;
    pkeep  = 1'b1;
    lq     = '0;
    lp     = '0;
    for (int k = 0; k < DEPTH; k++) begin
      cur_q[k] = gsel_r ? sq_r[k] : bq_r[k];
      cur_p[k] = gsel_r ? sp_r[k] : bp_r[k];
      keep = (CW'(k) < ins_n) &&
             (gsel_r ? (cur_p[k] <= ins_p) : (cur_p[k] >= ins_p));
      if (keep) begin
        new_q[k] = cur_q[k];
        new_p[k] = cur_p[k];
      end else if (pkeep) begin
        new_q[k] = ins_q;
        new_p[k] = ins_p;
      end else begin
        new_q[k] = lq;
        new_p[k] = lp;
      end
      pkeep = keep;
      lq = cur_q[k];
      lp = cur_p[k];
    end
  end

  // Trade unit on the two heads
  logic [QW-1:0] fill_q;
  logic          trade_go;
  assign fill_q   = (bq_r[0] < sq_r[0]) ? bq_r[0] : sq_r[0];
  assign trade_go = (nb_r != '0) && (ns_r != '0) && (bp_r[0] >= sp_r[0]) &&
                    (trd_r < TRADE_CAP);

  assign add_room = (side_r == SIDE_SELL) ? (scnt_q < CW'(DEPTH))
                                          : (bcnt_q < CW'(DEPTH));

  // Memory port control
  always_comb begin
    book_raddr = base_r + AW'(gidx_r);
    book_waddr = base_r + AW'(widx_r);
    book_wdata = {price_r, qty_r};
    buy_we  = 1'b0;
    sell_we = 1'b0;
    bcnt_we = 1'b0;
    scnt_we = 1'b0;
    cnt_addr   = tki_r;
    bcnt_wdata = nbf_r;
    scnt_wdata = nsf_r;
    unique case (state_r)
      S_CLR: begin
        cnt_addr   = clr_r;
        bcnt_we    = 1'b1;
        scnt_we    = 1'b1;
        bcnt_wdata = '0;
        scnt_wdata = '0;
      end
      S_DEC: begin
        if (op_r == OP_ADD && ok_r && add_room) begin
          if (side_r == SIDE_SELL) begin
            book_waddr = base_r + AW'(scnt_q);
            sell_we    = 1'b1;
            scnt_we    = 1'b1;
            scnt_wdata = scnt_q + CW'(1);
          end else begin
            book_waddr = base_r + AW'(bcnt_q);
            buy_we     = 1'b1;
            bcnt_we    = 1'b1;
            bcnt_wdata = bcnt_q + CW'(1);
          end
        end
      end
      S_WBUY: begin
        book_wdata = {bp_r[0], bq_r[0]};
        buy_we     = (nb_r != '0);
      end
      S_WSELL: begin
        book_wdata = {sp_r[0], sq_r[0]};
        sell_we    = (ns_r != '0);
      end
      S_FIN: begin
        bcnt_we = 1'b1;
        scnt_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Book memories: one write, one registered read each
  always_ff @(posedge clk) begin
    if (buy_we) buy_mem[book_waddr] <= book_wdata;
    buy_rd_q <= buy_mem[book_raddr];
  end

  always_ff @(posedge clk) begin
    if (sell_we) sell_mem[book_waddr] <= book_wdata;
    sell_rd_q <= sell_mem[book_raddr];
  end

  // Count memories: read at the incoming ticker while idle
  always_ff @(posedge clk) begin
    if (bcnt_we) bcnt_mem[cnt_addr] <= bcnt_wdata;
    bcnt_q <= bcnt_mem[(state_r == S_IDLE) ? in_tki : tki_r];
  end

  always_ff @(posedge clk) begin
    if (scnt_we) scnt_mem[cnt_addr] <= scnt_wdata;
    scnt_q <= scnt_mem[(state_r == S_IDLE) ? in_tki : tki_r];
  end

  // Sequencer, lanes and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
      ol_r    <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + TW'(1);
          if (32'(clr_r) == TICKERS - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op_r    <= in_op;
            side_r  <= in_side;
            tk_r    <= in_ticker;
            tki_r   <= in_tki;
            ok_r    <= in_ok;
            qty_r   <= in_quantity;
            price_r <= in_price;
            base_r  <= AW'(in_tki) * AW'(DEPTH);
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          oq_r       <= '0;
          op_price_r <= '0;
          ol_r       <= 1'b1;
          if (op_r == OP_ADD) begin
            ov_r      <= 1'b1;
            ok_kind_r <= (ok_r && add_room) ? KIND_ACCEPT : KIND_DROP;
            state_r   <= S_IDLE;
          end else if (!ok_r || bcnt_q == '0 || scnt_q == '0) begin
            ov_r      <= 1'b1;
            ok_kind_r <= KIND_DONE;
            state_r   <= S_IDLE;
          end else begin
            gsel_r  <= SIDE_BUY;
            gidx_r  <= '0;
            pend_r  <= 1'b0;
            nb_r    <= '0;
            ns_r    <= '0;
            trd_r   <= '0;
            state_r <= S_GATH;
          end
        end
        S_GATH: begin
          // issue the next read, insert the entry that arrived
          if (gidx_r < (gsel_r ? scnt_q : bcnt_q)) begin
            gidx_r <= gidx_r + CW'(1);
            pend_r <= 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          if (pend_r && ins_ok) begin
            if (gsel_r) begin
              sq_r <= new_q;
              sp_r <= new_p;
              ns_r <= ns_r + CW'(1);
            end else begin
              bq_r <= new_q;
              bp_r <= new_p;
              nb_r <= nb_r + CW'(1);
            end
          end
          if (!pend_r && gidx_r == (gsel_r ? scnt_q : bcnt_q)) begin
            if (gsel_r) begin
              state_r <= S_TRADE;
            end else begin
              gsel_r <= SIDE_SELL;
              gidx_r <= '0;
            end
          end
        end
        S_TRADE: begin
          if (trade_go) begin
            ov_r       <= 1'b1;
            ol_r       <= 1'b0;
            ok_kind_r  <= KIND_TRADE;
            oq_r       <= fill_q;
            op_price_r <= sp_r[0];
            trd_r      <= trd_r + 5'd1;
            bq_r[0]    <= bq_r[0] - fill_q;
            sq_r[0]    <= sq_r[0] - fill_q;
            // drop filled heads
            if (bq_r[0] == fill_q) begin
              for (int k = 0; k < DEPTH - 1; k++) begin
                bq_r[k] <= bq_r[k+1];
                bp_r[k] <= bp_r[k+1];
              end
              nb_r <= nb_r - CW'(1);
            end
            if (sq_r[0] == fill_q) begin
              for (int k = 0; k < DEPTH - 1; k++) begin
                sq_r[k] <= sq_r[k+1];
                sp_r[k] <= sp_r[k+1];
              end
              ns_r <= ns_r - CW'(1);
            end
          end else begin
            nbf_r   <= nb_r;
            nsf_r   <= ns_r;
            widx_r  <= '0;
            state_r <= S_WBUY;
          end
        end
        S_WBUY: begin
          if (nb_r != '0) begin
            for (int k = 0; k < DEPTH - 1; k++) begin
              bq_r[k] <= bq_r[k+1];
              bp_r[k] <= bp_r[k+1];
            end
            nb_r   <= nb_r - CW'(1);
            widx_r <= widx_r + CW'(1);
          end else begin
            widx_r  <= '0;
            state_r <= S_WSELL;
          end
        end
        S_WSELL: begin
          if (ns_r != '0) begin
            for (int k = 0; k < DEPTH - 1; k++) begin
              sq_r[k] <= sq_r[k+1];
              sp_r[k] <= sp_r[k+1];
            end
            ns_r   <= ns_r - CW'(1);
            widx_r <= widx_r + CW'(1);
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          ov_r       <= 1'b1;
          ol_r       <= 1'b1;
          ok_kind_r  <= KIND_DONE;
          oq_r       <= '0;
          op_price_r <= '0;
          state_r    <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/obm_checker.sv
// Port-level checks of the order book matcher, bound to the top level.
`include "order_book_matcher_unit_macros.svh"
module obm_checker
  import obm_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input logic [KW-1:0] out_kind,
  input logic [QW-1:0] out_trade_quantity,
  input logic          out_last
);
  `OBM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `OBM_ASSERT_NOW(a_trade_not_last, out_valid && out_kind == KIND_TRADE, !out_last)
  `OBM_ASSERT_NOW(a_other_last, out_valid && out_kind != KIND_TRADE, out_last)
  `OBM_ASSERT_NOW(a_trade_nonzero, out_valid && out_kind == KIND_TRADE,
                  out_trade_quantity != '0)
  `OBM_ASSERT_NEXT(a_last_gap, out_valid && out_last, !out_valid)
endmodule

bind order_book_matcher_unit obm_checker u_obm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_kind           (out_kind),
  .out_trade_quantity (out_trade_quantity),
  .out_last           (out_last)
);
